// ===== hdl/wuf_pkg.sv =====
`timescale 1ns / 1ps

package wuf_pkg;

  // Node index fields on the stream ports
  localparam int unsigned NodeW = 10;

  // Byte-padded stream widths
  localparam int unsigned SDataW = 24;
  localparam int unsigned MDataW = 24;

  // One finished result, handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic             merged;
    logic [NodeW-1:0] echo_first;
    logic [NodeW-1:0] echo_second;
  } res_t;

endpackage

// ===== hdl/wuf_store.sv =====
`timescale 1ns / 1ps

module wuf_store #(
  parameter int unsigned NODE_COUNT = 1024,
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned WGT_W      = 11
) (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [IDX_W-1:0] rd_par_o,
  output logic [WGT_W-1:0] rd_wgt_o,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic             wr_par_en_i,
  input  logic             wr_wgt_en_i,
  input  logic [IDX_W-1:0] wr_par_i,
  input  logic [WGT_W-1:0] wr_wgt_i
);

  logic [IDX_W-1:0] par_mem [NODE_COUNT];
  logic [WGT_W-1:0] wgt_mem [NODE_COUNT];

  always_ff @(posedge clk_i) begin
    if (wr_par_en_i) begin
      par_mem[wr_addr_i] <= wr_par_i;
    end
    rd_par_o <= par_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_wgt_en_i) begin
      wgt_mem[wr_addr_i] <= wr_wgt_i;
    end
    rd_wgt_o <= wgt_mem[rd_addr_i];
  end

endmodule

// ===== hdl/wuf_ctrl.sv =====
`timescale 1ns / 1ps

module wuf_ctrl #(
  parameter int unsigned NODE_COUNT = 1024,
  parameter int unsigned IDX_W      = 10,
  parameter int unsigned WGT_W      = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input item
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [wuf_pkg::NodeW-1:0] first_i,
  input  logic [wuf_pkg::NodeW-1:0] second_i,
  // result
  output wuf_pkg::res_t             res_o,
  input  logic                      res_ready_i,
  // store
  output logic [IDX_W-1:0]          rd_addr_o,
  input  logic [IDX_W-1:0]          rd_par_i,
  input  logic [WGT_W-1:0]          rd_wgt_i,
  output logic [IDX_W-1:0]          wr_addr_o,
  output logic                      wr_par_en_o,
  output logic                      wr_wgt_en_o,
  output logic [IDX_W-1:0]          wr_par_o,
  output logic [WGT_W-1:0]          wr_wgt_o
);

  localparam logic [2:0] StInit  = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StWalkA = 3'd2;
  localparam logic [2:0] StWalkB = 3'd3;
  localparam logic [2:0] StUpd   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NODE_COUNT - 1);

  logic [2:0]                state_q, state_d;
  logic [IDX_W-1:0]          cur_q, cur_d;     // walk pointer, sweep counter after reset
  logic [IDX_W-1:0]          ra_q, ra_d;
  logic [WGT_W-1:0]          wa_q, wa_d;
  logic [IDX_W-1:0]          tgt_q, tgt_d;
  logic [WGT_W-1:0]          sum_q, sum_d;
  logic                      merged_q, merged_d;
  logic [wuf_pkg::NodeW-1:0] a_q, a_d;
  logic [wuf_pkg::NodeW-1:0] b_q, b_d;
  logic                      in_range;
  logic                      at_root;

  assign in_range = (32'(first_i) < NODE_COUNT) && (32'(second_i) < NODE_COUNT);
  assign at_root  = (rd_par_i == cur_q);

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    ra_d        = ra_q;
    wa_d        = wa_q;
    tgt_d       = tgt_q;
    sum_d       = sum_q;
    merged_d    = merged_q;
    a_d         = a_q;
    b_d         = b_q;
    wr_addr_o   = cur_q;
    wr_par_en_o = 1'b0;
    wr_wgt_en_o = 1'b0;
    wr_par_o    = cur_q;
    wr_wgt_o    = WGT_W'(1);
    res_o       = '{valid: 1'b0, merged: merged_q, echo_first: a_q, echo_second: b_q};

    unique case (state_q)
      StInit: begin
        wr_par_en_o = 1'b1;
        wr_wgt_en_o = 1'b1;
        cur_d       = cur_q + 1'b1;
        if (cur_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          a_d      = first_i;
          b_d      = second_i;
          merged_d = 1'b0;
          cur_d    = IDX_W'(first_i);
          state_d  = in_range ? StWalkA : StDone;
        end
      end
      StWalkA: begin
        if (at_root) begin
          ra_d    = cur_q;
          wa_d    = rd_wgt_i;
          cur_d   = IDX_W'(b_q);
          state_d = StWalkB;
        end else begin
          cur_d = rd_par_i;
        end
      end
      StWalkB: begin
        if (!at_root) begin
          cur_d = rd_par_i;
        end else if (cur_q == ra_q) begin
          state_d = StDone;
        end else begin
          // lighter root goes under heavier; tie keeps the first root on top
          wr_par_en_o = 1'b1;
          if (wa_q < rd_wgt_i) begin
            wr_addr_o = ra_q;
            wr_par_o  = cur_q;
            tgt_d     = cur_q;
          end else begin
            wr_addr_o = cur_q;
            wr_par_o  = ra_q;
            tgt_d     = ra_q;
          end
          sum_d    = wa_q + rd_wgt_i;
          merged_d = 1'b1;
          state_d  = StUpd;
        end
      end
      StUpd: begin
        wr_addr_o   = tgt_q;
        wr_wgt_en_o = 1'b1;
        wr_wgt_o    = sum_q;
        state_d     = StDone;
      end
      StDone: begin
        if (res_ready_i) begin
          res_o.valid = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // read address follows the next walk pointer so data lines up with cur_q
  assign rd_addr_o = cur_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q     <= ra_d;
    wa_q     <= wa_d;
    tgt_q    <= tgt_d;
    sum_q    <= sum_d;
    merged_q <= merged_d;
    a_q      <= a_d;
    b_q      <= b_d;
  end

endmodule

// ===== hdl/weighted_union_find.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Fields (tdata, lowest bit first)
// s_axis   in   first_node[9:0], second_node[19:10], zero pad to 24 bits
// m_axis   out  merged[0], echo_first[10:1], echo_second[20:11], zero pad to 24 bits
//
// Each pair walks from the first node to its root, then from the second node to its root;
// a join writes the parent link, then the new weight. Each walk step is one registered store read.
// Pairs already connected skip the writes; out-of-range pairs skip the walks as well.
// After reset a clearing pass sets both stores; tready stays low until it ends.
// A finished beat waits in the output register; the next item is taken meanwhile,
// and the sequencer holds its result only if that register is still full.

module weighted_union_find #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [wuf_pkg::SDataW-1:0]   s_axis_tdata_i,  // first_node, second_node
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [wuf_pkg::MDataW-1:0]   m_axis_tdata_o   // merged, echo_first, echo_second
);

  localparam int unsigned IDX_W = $clog2(NODE_COUNT);
  localparam int unsigned WGT_W = $clog2(NODE_COUNT + 1);
  localparam int unsigned NW    = wuf_pkg::NodeW;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rd_par;
  logic [WGT_W-1:0] rd_wgt;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_par_en;
  logic             wr_wgt_en;
  logic [IDX_W-1:0] wr_par;
  logic [WGT_W-1:0] wr_wgt;
  wuf_pkg::res_t    res;
  logic             res_ready;

  logic             out_valid_q;
  logic             out_merged_q;
  logic [NW-1:0]    out_first_q;
  logic [NW-1:0]    out_second_q;

  wuf_store #(
    .NODE_COUNT (NODE_COUNT),
    .IDX_W      (IDX_W),
    .WGT_W      (WGT_W)
  ) u_store (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .rd_par_o    (rd_par),
    .rd_wgt_o    (rd_wgt),
    .wr_addr_i   (wr_addr),
    .wr_par_en_i (wr_par_en),
    .wr_wgt_en_i (wr_wgt_en),
    .wr_par_i    (wr_par),
    .wr_wgt_i    (wr_wgt)
  );

  wuf_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .IDX_W      (IDX_W),
    .WGT_W      (WGT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .first_i     (s_axis_tdata_i[NW-1:0]),
    .second_i    (s_axis_tdata_i[2*NW-1:NW]),
    .res_o       (res),
    .res_ready_i (res_ready),
    .rd_addr_o   (rd_addr),
    .rd_par_i    (rd_par),
    .rd_wgt_i    (rd_wgt),
    .wr_addr_o   (wr_addr),
    .wr_par_en_o (wr_par_en),
    .wr_wgt_en_o (wr_wgt_en),
    .wr_par_o    (wr_par),
    .wr_wgt_o    (wr_wgt)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_merged_q <= res.merged;
      out_first_q  <= res.echo_first;
      out_second_q <= res.echo_second;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(wuf_pkg::MDataW - 2*NW - 1)'(0),
                            out_second_q, out_first_q, out_merged_q};

endmodule

// ===== sim/wuf_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own forest of parent links and tree
// weights, and compares every output beat with the oldest predicted result.
module wuf_checker #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [wuf_pkg::SDataW-1:0]  s_tdata_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [wuf_pkg::MDataW-1:0]  m_tdata_i,
  output int                          error_count_o,
  output int                          pending_count_o
);

  localparam int unsigned NW = wuf_pkg::NodeW;

  typedef struct packed {
    logic          merged;
    logic [NW-1:0] first;
    logic [NW-1:0] second;
  } link_result_t;

  logic [NW-1:0] parent_of [NODE_COUNT];
  logic [NW:0]   weight_of [NODE_COUNT];
  link_result_t  link_results_q [$];
  int            errors;

  function automatic logic [NW-1:0] root_of(input logic [NW-1:0] node);
    logic [NW-1:0] cur;
    int            steps;
    cur = node;
    steps = 0;
    while (steps < NODE_COUNT && parent_of[cur] != cur) begin
      if (parent_of[cur] >= NODE_COUNT) break;
      cur = parent_of[cur];
      steps++;
    end
    return cur;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    link_result_t  want;
    link_result_t  got;
    logic [NW-1:0] first_root;
    logic [NW-1:0] second_root;
    if (!rst_ni) begin
      for (int k = 0; k < NODE_COUNT; k++) begin
        parent_of[k] = NW'(k);
        weight_of[k] = 1;
      end
      link_results_q.delete();
      errors = 0;
      error_count_o <= 0;
      pending_count_o <= 0;
    end else begin
      // check the outgoing beat first: it can never belong to a pair taken this edge
      if (m_tvalid_i && m_tready_i) begin
        got.merged = m_tdata_i[0];
        got.first  = m_tdata_i[NW:1];
        got.second = m_tdata_i[2*NW:NW+1];
        if (link_results_q.size() == 0) begin
          $error("result beat with no pair outstanding: merged=%0d first=%0d second=%0d",
                 got.merged, got.first, got.second);
          errors++;
        end else begin
          want = link_results_q.pop_front();
          if (got.merged !== want.merged) begin
            $error("merged: expected %0d, actual %0d", want.merged, got.merged);
            errors++;
          end
          if (got.first !== want.first) begin
            $error("echo_first: expected %0d, actual %0d", want.first, got.first);
            errors++;
          end
          if (got.second !== want.second) begin
            $error("echo_second: expected %0d, actual %0d", want.second, got.second);
            errors++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        want.first  = s_tdata_i[NW-1:0];
        want.second = s_tdata_i[2*NW-1:NW];
        want.merged = 1'b0;
        if (want.first < NODE_COUNT && want.second < NODE_COUNT) begin
          first_root  = root_of(want.first);
          second_root = root_of(want.second);
          if (first_root != second_root) begin
            // lighter root goes under the heavier one; ties favor the first root
            if (weight_of[first_root] < weight_of[second_root]) begin
              parent_of[first_root] = second_root;
              weight_of[second_root] += weight_of[first_root];
            end else begin
              parent_of[second_root] = first_root;
              weight_of[first_root] += weight_of[second_root];
            end
            want.merged = 1'b1;
          end
        end
        link_results_q.push_back(want);
      end

      error_count_o <= errors;
      pending_count_o <= link_results_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NODES = 1024;
  localparam int unsigned NW = wuf_pkg::NodeW;
  localparam int          RANDOM_PAIRS = 1200;

  typedef enum int {RxFull, RxHalf, RxSparse, RxMostly, RxHold} rx_mode_e;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [wuf_pkg::SDataW-1:0] s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [wuf_pkg::MDataW-1:0] m_tdata;
  int                         error_count;
  int                         pending_count;

  int pairs_sent = 0;
  int burst_left = 0;

  weighted_union_find #(
    .NODE_COUNT(NODES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  wuf_checker #(
    .NODE_COUNT(NODES)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_tvalid),
    .s_tready_i     (s_tready),
    .s_tdata_i      (s_tdata),
    .m_tvalid_i     (m_tvalid),
    .m_tready_i     (m_tready),
    .m_tdata_i      (m_tdata),
    .error_count_o  (error_count),
    .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Offer one pair and wait until it is accepted; bursts end in a random gap.
  task automatic offer_pair(input logic [NW-1:0] first_node, input logic [NW-1:0] second_node);
    int gap_cycles;
    s_tvalid <= 1'b1;
    s_tdata <= {{(wuf_pkg::SDataW - 2*NW){1'b0}}, second_node, first_node};
    do @(posedge clk_i); while (!s_tready);
    pairs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap_cycles = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Join an aligned block of 2**span nodes level by level: equal weights every time,
  // so the tree grows as deep as weighted linking allows, then probe it.
  task automatic build_block(input int span);
    logic [NW-1:0] base;
    logic [NW-1:0] lo_node;
    logic [NW-1:0] hi_node;
    int            reach;
    base = NW'($urandom) & ~NW'((1 << span) - 1);
    for (int lvl = 0; lvl < span; lvl++) begin
      reach = 1 << lvl;
      for (int i = 0; i < (1 << span); i += 2 * reach) begin
        lo_node = base + NW'(i);
        hi_node = base + NW'(i + reach);
        if ($urandom_range(0, 1)) offer_pair(lo_node, hi_node);
        else offer_pair(hi_node, lo_node);
      end
    end
    repeat (3) offer_pair(base + NW'($urandom_range(0, (1 << span) - 1)),
                          base + NW'($urandom_range(0, (1 << span) - 1)));
  endtask

  // Receiver: stretches of different stall patterns, one long hold-off.
  initial begin
    rx_mode_e mode;
    int       stretch;
    int       rx_cycles;
    bit       held;
    rx_cycles = 0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      stretch = $urandom_range(10, 150);
      if (!held && rx_cycles > 3000) begin
        mode = RxHold;
        stretch = 600;
        held = 1'b1;
      end
      repeat (stretch) begin
        case (mode)
          RxFull: begin
            m_tready <= 1'b1;
          end
          RxHalf: begin
            m_tready <= $urandom_range(0, 1);
          end
          RxSparse: begin
            m_tready <= ($urandom_range(0, 3) == 0);
          end
          RxMostly: begin
            m_tready <= ($urandom_range(0, 9) != 0);
          end
          default: begin
            m_tready <= 1'b0;
          end
        endcase
        @(posedge clk_i);
        rx_cycles++;
      end
    end
  end

  initial begin
    int kind;
    int random_target;
    bit paused;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // same node twice, extremes, ties, lighter-under-heavier both ways
    offer_pair(10'd0, 10'd0);
    offer_pair(10'd1023, 10'd1023);
    offer_pair(10'd0, 10'd1023);
    offer_pair(10'd1023, 10'd0);
    offer_pair(10'h2AA, 10'h155);
    offer_pair(10'h155, 10'h2AA);
    offer_pair(10'd1, 10'd2);
    offer_pair(10'd3, 10'd4);
    offer_pair(10'd1, 10'd3);
    offer_pair(10'd2, 10'd4);
    offer_pair(10'd5, 10'd1);
    offer_pair(10'd1, 10'd0);
    offer_pair(10'd6, 10'd4);
    offer_pair(10'd1023, 10'd6);
    offer_pair(10'd7, 10'd8);
    offer_pair(10'd7, 10'd8);
    offer_pair(10'h2AA, 10'd2);

    random_target = pairs_sent + RANDOM_PAIRS;
    paused = 1'b0;
    while (pairs_sent < random_target) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        offer_pair(NW'($urandom), NW'($urandom));
      end else if (kind < 7) begin
        // pairs within a narrow window reach already-joined sets often
        offer_pair(NW'($urandom_range(0, 31)) + 10'd300, NW'($urandom_range(0, 31)) + 10'd300);
      end else if (kind < 9) begin
        build_block($urandom_range(2, 5));
      end else begin
        kind = $urandom;
        offer_pair(NW'(kind), NW'(kind));
      end
      if (!paused && pairs_sent > random_target - RANDOM_PAIRS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (60) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
